// ===== sv/plc_pkg.sv =====
package plc_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } opc_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } fsm_t;

  // request beat
  typedef struct packed {
    logic [1:0]              opcode;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  // result beat
  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]        count;
    logic                    is_empty;
    logic [1:0]              status;
  } rsp_t;

  // control broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic                    snap;
    logic                    scan;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

// ===== sv/plc_cell.sv =====
module plc_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  logic                               clk,
  input  plc_pkg::cell_ctl_t                 ctl,
  input  logic [CW-1:0]                      pos,
  input  logic signed [plc_pkg::DATA_W-1:0]  left_entry,
  input  logic signed [plc_pkg::DATA_W-1:0]  right_entry,
  input  logic signed [plc_pkg::DATA_W-1:0]  right_snap,
  output logic signed [plc_pkg::DATA_W-1:0]  entry,
  output logic signed [plc_pkg::DATA_W-1:0]  snap
);
  import plc_pkg::*;

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  // stored entry: at and above pos, shift up on insert and down on remove; hold otherwise
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (IDX > pos) begin
        entry <= left_entry;
      end else if (IDX == pos) begin
        entry <= ctl.value;
      end
    end else if (ctl.rem) begin
      if (IDX >= pos) begin
        entry <= right_entry;
      end
    end
  end

  // snapshot lane: loaded from the entry, then walked towards cell 0
  always_ff @(posedge clk) begin
    if (ctl.snap) begin
      snap <= entry;
    end else if (ctl.scan) begin
      snap <= right_snap;
    end
  end

endmodule

// ===== sv/positional_list_store.sv =====
// Channel   Ports              Beat type   Handshake
// request   start, busy, req   req_t       taken when start && !busy
// result    done, rsp          rsp_t       one-cycle strobe, always taken
//
// done is registered when the walk state reaches a zero count. Insert and
// rejected requests enter it with a zero count; remove and read load the position,
// and the entry walks one cell per cycle down the snapshot lane to cell 0.
// busy is high from the cycle after the request beat until done is shown.
// Reset clears the fill count; entries are not cleared and need no pass.
// The result side has no back-pressure.
module positional_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  plc_pkg::req_t req,
  output logic          done,
  output plc_pkg::rsp_t rsp
);
  import plc_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  fsm_t                    state, state_next;
  logic [CW-1:0]           fill, fill_next;
  logic [POS_W-1:0]        cnt;
  logic                    need_data, need_data_next;
  logic [POS_W-1:0]        res_count;
  logic                    res_empty;
  logic [1:0]              res_status;
  status_t                 status_c;
  logic                    accept;
  logic                    scan;
  logic [CMPW-1:0]         pos_x, fill_x, fill_nx;
  cell_ctl_t               ctl;
  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic signed [DATA_W-1:0] snap  [CAPACITY];

  assign accept = start && !busy;
  assign pos_x  = CMPW'(req.position);
  assign fill_x = CMPW'(fill);

  // status and new fill for the request on the port
  always_comb begin
    status_c       = ST_BADPOS;
    fill_next      = fill;
    need_data_next = 1'b0;
    case (opc_t'(req.opcode))
      OP_INSERT: begin
        if (pos_x > fill_x) begin
          status_c = ST_BADPOS;
        end else if (fill_x == CMPW'(CAPACITY)) begin
          status_c = ST_FULL;
        end else begin
          status_c  = ST_OK;
          fill_next = fill + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_x < fill_x) begin
          status_c       = ST_OK;
          fill_next      = fill - 1'b1;
          need_data_next = 1'b1;
        end
      end
      OP_READ: begin
        if (pos_x < fill_x) begin
          status_c       = ST_OK;
          need_data_next = 1'b1;
        end
      end
      default: status_c = ST_BADPOS;
    endcase
  end

  assign fill_nx = CMPW'(fill_next);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_WALK;
      S_WALK: if (cnt == '0) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and cell control
  always_comb begin
    busy      = (state != S_IDLE);
    scan      = (state == S_WALK) && (cnt != '0);
    ctl.ins   = accept && (status_c == ST_OK) && (req.opcode == OP_INSERT);
    ctl.rem   = accept && (status_c == ST_OK) && (req.opcode == OP_REMOVE);
    ctl.snap  = accept;
    ctl.scan  = scan;
    ctl.value = req.value;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      done  <= (state == S_WALK) && (cnt == '0);
      if (accept) begin
        fill <= fill_next;
        cnt  <= need_data_next ? req.position : '0;
      end else if (scan) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // result fields captured at the request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      need_data  <= need_data_next;
      res_count  <= fill_nx[POS_W-1:0];
      res_empty  <= (fill_next == '0);
      res_status <= status_c;
    end
  end

  // result beat: data picked off cell 0 when the walk ends
  always_ff @(posedge clk) begin
    if ((state == S_WALK) && (cnt == '0)) begin
      rsp.data_out <= need_data ? snap[0] : '0;
      rsp.count    <= res_count;
      rsp.is_empty <= res_empty;
      rsp.status   <= res_status;
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_e, right_e, right_s;
    if (i == 0) begin : g_first
      assign left_e = req.value;
    end else begin : g_left
      assign left_e = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
      assign right_s = '0;
    end else begin : g_right
      assign right_e = entry[i+1];
      assign right_s = snap[i+1];
    end
    plc_cell #(
      .INDEX (i),
      .CW    (CMPW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .pos         (pos_x),
      .left_entry  (left_e),
      .right_entry (right_e),
      .right_snap  (right_s),
      .entry       (entry[i]),
      .snap        (snap[i])
    );
  end

`ifndef SYNTHESIS
  // fill never runs past capacity
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    fill_x <= CMPW'(CAPACITY))
    else $error("fill count above capacity");

  // a request beat makes the block busy on the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("not busy after request beat");

  // done only ends a walk
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_WALK) && !busy)
    else $error("done without a finished walk");

  // fill moves by at most one per cycle
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (fill == $past(fill)) || (fill == $past(fill) + 1'b1) ||
             (fill == $past(fill) - 1'b1))
    else $error("fill count jumped");
`endif

endmodule

// ===== tb/positional_list_store_tb.sv =====
module positional_list_store_tb;
  import plc_pkg::*;

  localparam int CAP = 16;
  localparam int LIMIT = 200000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [POS_W-1:0] POS_TOP = 5'd31;
  localparam logic signed [DATA_W-1:0] V_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] V_MIN = 32'sh80000000;

  // one directed row: a request beat, a repeat count and an optional typed result
  typedef struct {
    req_t beat;
    int   rep;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  // shadow copy of the sequence held by the block
  logic signed [DATA_W-1:0] list_vals [CAP];
  int                       list_fill;

  rsp_t      rsp_due [$];
  stim_row_t plan [$];
  int        mismatches;
  int        cycle_count;

  positional_list_store #(.CAPACITY(CAP)) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", rsp_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic note_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch on %s: got %h, want %h (cycle %0d)", field, got, want, cycle_count);
    mismatches++;
  endtask

  // insert/remove/read at an index against the shadow sequence
  function automatic rsp_t apply_list_op(input req_t beat);
    rsp_t    res;
    status_t st;
    int      p;
    int      i;
    res = '0;
    st  = ST_OK;
    p   = int'(beat.position);
    case (beat.opcode)
      OP_INSERT: begin
        if (p > list_fill) begin
          st = ST_BADPOS;
        end else if (list_fill >= CAP) begin
          st = ST_FULL;
        end else begin
          for (i = list_fill; i > p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p] = beat.value;
          list_fill++;
        end
      end
      OP_REMOVE: begin
        if (p >= list_fill) begin
          st = ST_BADPOS;
        end else begin
          res.data_out = list_vals[p];
          for (i = p; i + 1 < list_fill; i++) list_vals[i] = list_vals[i+1];
          list_fill--;
        end
      end
      OP_READ: begin
        if (p >= list_fill) st = ST_BADPOS;
        else res.data_out = list_vals[p];
      end
      default: st = ST_BADPOS;
    endcase
    res.count    = list_fill[POS_W-1:0];
    res.is_empty = (list_fill == 0);
    res.status   = st;
    return res;
  endfunction

  // result checker: every strobe is matched against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (rsp_due.size() == 0) begin
        note_mismatch("unexpected result", 32'(rsp), 32'd0);
      end else begin
        want = rsp_due.pop_front();
        if (rsp.data_out !== want.data_out)
          note_mismatch("data_out", rsp.data_out, want.data_out);
        if (rsp.count !== want.count) note_mismatch("count", 32'(rsp.count), 32'(want.count));
        if (rsp.is_empty !== want.is_empty)
          note_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
        if (rsp.status !== want.status)
          note_mismatch("status", 32'(rsp.status), 32'(want.status));
      end
    end
  end

  // drive one request beat from a falling edge, return at the falling edge after it is taken
  task automatic send_beat(input req_t beat, input bit use_table, input rsp_t table_rsp);
    rsp_t due;
    start <= 1'b1;
    req   <= beat;
    do @(posedge clk); while (busy !== 1'b0);
    due = apply_list_op(beat);
    rsp_due.push_back(use_table ? table_rsp : due);
    @(negedge clk);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // sender waits until every outstanding result has come back
  task automatic drain;
    start <= 1'b0;
    do @(negedge clk); while (rsp_due.size() != 0);
  endtask

  task automatic add_row(input logic [1:0] op, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] val, input int rep, input bit typed,
                         input logic [DATA_W-1:0] d, input logic [POS_W-1:0] cnt,
                         input status_t st);
    stim_row_t row;
    row.beat.opcode    = op;
    row.beat.position  = pos;
    row.beat.value     = val;
    row.rep            = rep;
    row.typed          = typed;
    row.want.data_out  = d;
    row.want.count     = cnt;
    row.want.is_empty  = (cnt == 0);
    row.want.status    = st;
    plan.push_back(row);
  endtask

  initial begin
    req_t beat;
    int   k;
    int   ph;
    int   ins_pct;
    int   idle_pct [4];
    rsp_t none;

    idle_pct = '{0, 59, 0, 13};
    none     = '0;
    mismatches  = 0;
    cycle_count = 0;
    list_fill   = 0;
    foreach (list_vals[i]) list_vals[i] = '0;
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty store, bad positions, extremes, full store, draining to empty
    add_row(OP_READ,   5'd0,  32'd0, 1, 1, 32'd0, 5'd0, ST_BADPOS);
    add_row(OP_REMOVE, 5'd0,  32'd0, 1, 1, 32'd0, 5'd0, ST_BADPOS);
    add_row(OP_INSERT, 5'd1,  32'd5, 1, 1, 32'd0, 5'd0, ST_BADPOS);
    add_row(OP_UNUSED, 5'd0,  32'd9, 1, 1, 32'd0, 5'd0, ST_BADPOS);
    add_row(OP_INSERT, 5'd0,  V_MAX, 1, 1, 32'd0, 5'd1, ST_OK);
    add_row(OP_INSERT, 5'd0,  V_MIN, 1, 1, 32'd0, 5'd2, ST_OK);
    add_row(OP_INSERT, 5'd2,  -32'sd1, 1, 1, 32'd0, 5'd3, ST_OK);
    add_row(OP_READ,   POS_TOP, 32'd0, 1, 1, 32'd0, 5'd3, ST_BADPOS);
    add_row(OP_READ,   5'd0,  32'd0, 1, 1, V_MIN, 5'd3, ST_OK);
    add_row(OP_READ,   5'd2,  32'd0, 1, 1, -32'sd1, 5'd3, ST_OK);
    add_row(OP_REMOVE, 5'd1,  32'd0, 1, 1, V_MAX, 5'd2, ST_OK);
    add_row(OP_REMOVE, 5'd2,  32'd0, 1, 1, 32'd0, 5'd2, ST_BADPOS);
    add_row(OP_INSERT, 5'd1,  32'd0, 14, 0, 32'd0, 5'd0, ST_OK);
    add_row(OP_INSERT, 5'd16, 32'd1, 1, 1, 32'd0, 5'd16, ST_FULL);
    add_row(OP_INSERT, 5'd17, 32'd1, 1, 1, 32'd0, 5'd16, ST_BADPOS);
    add_row(OP_INSERT, 5'd0,  32'd1, 1, 1, 32'd0, 5'd16, ST_FULL);
    add_row(OP_READ,   5'd15, 32'd0, 1, 1, -32'sd1, 5'd16, ST_OK);
    add_row(OP_READ,   5'd16, 32'd0, 1, 1, 32'd0, 5'd16, ST_BADPOS);
    add_row(OP_REMOVE, 5'd15, 32'd0, 1, 1, -32'sd1, 5'd15, ST_OK);
    add_row(OP_REMOVE, 5'd0,  32'd0, 1, 1, V_MIN, 5'd14, ST_OK);
    add_row(OP_REMOVE, 5'd0,  32'd0, 14, 0, 32'd0, 5'd0, ST_OK);
    add_row(OP_READ,   5'd0,  32'd0, 1, 1, 32'd0, 5'd0, ST_BADPOS);

    foreach (plan[i]) begin
      for (k = 0; k < plan[i].rep; k++) begin
        beat = plan[i].beat;
        beat.value = plan[i].beat.value + k;
        send_beat(beat, plan[i].typed, plan[i].want);
      end
    end
    drain();

    // random: mostly well-formed positions, fill level swept between empty and full
    ins_pct = 70;
    for (ph = 0; ph < 4; ph++) begin
      for (k = 0; k < 250; k++) begin
        if (k % 40 == 0) ins_pct = (ins_pct == 70) ? 30 : 70;
        if ($urandom_range(0, 99) < 6) begin
          beat.opcode   = 2'($urandom_range(0, 3));
          beat.position = POS_W'($urandom_range(0, 31));
        end else begin
          if ($urandom_range(0, 99) < ins_pct) beat.opcode = OP_INSERT;
          else if ($urandom_range(0, 1) == 0) beat.opcode = OP_REMOVE;
          else beat.opcode = OP_READ;
          if (beat.opcode == OP_INSERT) beat.position = POS_W'($urandom_range(0, list_fill));
          else if (list_fill == 0) beat.position = '0;
          else beat.position = POS_W'($urandom_range(0, list_fill - 1));
        end
        case ($urandom_range(0, 9))
          0:       beat.value = V_MAX;
          1:       beat.value = V_MIN;
          2:       beat.value = '0;
          3:       beat.value = -32'sd1;
          default: beat.value = $urandom;
        endcase
        if ($urandom_range(0, 99) < idle_pct[ph]) hold_off($urandom_range(1, CAP + 4));
        send_beat(beat, 1'b0, none);
      end
      drain();
    end

    // let the block settle after the last result
    repeat (CAP + 4) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/plc_pkg.sv
sv/plc_cell.sv
sv/positional_list_store.sv
tb/positional_list_store_tb.sv
